// ===== hw/rtl/amms_pkg.sv =====
// Shared constants and width helpers for the audio min/max/rms summary block.
// Used by every module under hw/rtl; depends on nothing else.
package amms_pkg;

    localparam int DEF_SHORT_WINDOW      = 256;
    localparam int DEF_LONG_WINDOW       = 65536;
    localparam int DEF_MAX_BLOCK_SAMPLES = 1048576;
    localparam int DEF_SAMPLE_BITS       = 16;

    localparam int SUM_LIMIT   = 64;
    localparam int MAX_PUSH    = 3;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] LEVEL_SHORT = 2'd0;
    localparam logic [1:0] LEVEL_LONG  = 2'd1;
    localparam logic [1:0] LEVEL_BLOCK = 2'd2;

    function automatic int sum_width(input int sample_bits, input int max_block);
        int need;
        need = 2 * sample_bits - 2 + $clog2(max_block + 1);
        return (need > SUM_LIMIT) ? SUM_LIMIT : need;
    endfunction

    function automatic int count_width(input int short_win, input int long_win,
                                       input int max_block);
        int m;
        m = short_win;
        if (long_win > m) begin
            m = long_win;
        end
        if (max_block > m) begin
            m = max_block;
        end
        return $clog2(m + 1);
    endfunction

    function automatic int job_width(input int sample_bits, input int short_win,
                                     input int long_win, input int max_block);
        return 2 + 2 * sample_bits + sum_width(sample_bits, max_block)
               + count_width(short_win, long_win, max_block) + 1;
    endfunction

endpackage

// ===== hw/rtl/amms_front.sv =====
// Front end: takes samples, squares them and keeps min, max and sum of squares
// for the short window, the long window and the block. Uses amms_pkg.
module amms_front
    import amms_pkg::*;
#(
    parameter int SHORT_WINDOW      = DEF_SHORT_WINDOW,
    parameter int LONG_WINDOW       = DEF_LONG_WINDOW,
    parameter int MAX_BLOCK_SAMPLES = DEF_MAX_BLOCK_SAMPLES,
    parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS,
    parameter int JOB_W = job_width(SAMPLE_BITS, SHORT_WINDOW, LONG_WINDOW,
                                    MAX_BLOCK_SAMPLES)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample,
    input  logic                                 s_block_end,
    input  logic [QUEUE_CW-1:0]                  q_used,
    output logic [MAX_PUSH-1:0]                  push_en,
    output logic [MAX_PUSH-1:0][JOB_W-1:0]       push_data
);

    localparam int SUM_W = sum_width(SAMPLE_BITS, MAX_BLOCK_SAMPLES);
    localparam int CNT_W = count_width(SHORT_WINDOW, LONG_WINDOW, MAX_BLOCK_SAMPLES);
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int SC_W  = $clog2(SHORT_WINDOW + 1);
    localparam int LC_W  = $clog2(LONG_WINDOW + 1);
    localparam int BC_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam logic [SC_W-1:0] SHORT_LAST = SC_W'(SHORT_WINDOW);
    localparam logic [LC_W-1:0] LONG_LAST  = LC_W'(LONG_WINDOW);
    localparam logic [BC_W-1:0] BLOCK_LAST = BC_W'(MAX_BLOCK_SAMPLES);
    localparam logic [QUEUE_CW-1:0] READY_LIMIT = QUEUE_CW'(QUEUE_DEPTH - 2 * MAX_PUSH);

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [SQ_W-1:0] sq);
        logic [SUM_W:0] t;
        t = {1'b0, acc} + (SUM_W + 1)'(sq);
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [SQ_W-1:0]               s1_sq_reg;
    logic                          s1_end_reg;
    logic signed [SQ_W-1:0]        product;

    logic [SC_W-1:0] short_cnt_reg, short_inc, short_cnt_next;
    logic [LC_W-1:0] long_cnt_reg, long_inc, long_cnt_next;
    logic [BC_W-1:0] block_cnt_reg, block_inc, block_cnt_next;

    logic signed [SAMPLE_BITS-1:0] short_min_reg, short_max_reg, short_min_next, short_max_next;
    logic signed [SAMPLE_BITS-1:0] long_min_reg, long_max_reg, long_min_next, long_max_next;
    logic signed [SAMPLE_BITS-1:0] block_min_reg, block_max_reg, block_min_next, block_max_next;
    logic [SUM_W-1:0] short_sum_reg, long_sum_reg, block_sum_reg;
    logic [SUM_W-1:0] short_sum_next, long_sum_next, block_sum_next;

    logic blk_end, emit_short, emit_long, emit_block;

    assign product = s_sample * s_sample;
    assign s_ready = (q_used <= READY_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_valid && s_ready;
        end
        if (s_valid && s_ready) begin
            s1_sample_reg <= s_sample;
            s1_sq_reg     <= $unsigned(product);
            s1_end_reg    <= s_block_end;
        end
    end

    always_comb begin
        short_inc = short_cnt_reg + SC_W'(1);
        long_inc  = long_cnt_reg + LC_W'(1);
        block_inc = block_cnt_reg + BC_W'(1);

        short_min_next = (short_cnt_reg == '0 || s1_sample_reg < short_min_reg)
                         ? s1_sample_reg : short_min_reg;
        short_max_next = (short_cnt_reg == '0 || s1_sample_reg > short_max_reg)
                         ? s1_sample_reg : short_max_reg;
        short_sum_next = (short_cnt_reg == '0) ? SUM_W'(s1_sq_reg)
                         : sat_add(short_sum_reg, s1_sq_reg);

        long_min_next = (long_cnt_reg == '0 || s1_sample_reg < long_min_reg)
                        ? s1_sample_reg : long_min_reg;
        long_max_next = (long_cnt_reg == '0 || s1_sample_reg > long_max_reg)
                        ? s1_sample_reg : long_max_reg;
        long_sum_next = (long_cnt_reg == '0) ? SUM_W'(s1_sq_reg)
                        : sat_add(long_sum_reg, s1_sq_reg);

        block_min_next = (block_cnt_reg == '0 || s1_sample_reg < block_min_reg)
                         ? s1_sample_reg : block_min_reg;
        block_max_next = (block_cnt_reg == '0 || s1_sample_reg > block_max_reg)
                         ? s1_sample_reg : block_max_reg;
        block_sum_next = (block_cnt_reg == '0) ? SUM_W'(s1_sq_reg)
                         : sat_add(block_sum_reg, s1_sq_reg);

        blk_end    = s1_end_reg || (block_inc == BLOCK_LAST);
        emit_short = (short_inc == SHORT_LAST) || blk_end;
        emit_long  = (long_inc == LONG_LAST) || blk_end;
        emit_block = blk_end;

        short_cnt_next = emit_short ? '0 : short_inc;
        long_cnt_next  = emit_long ? '0 : long_inc;
        block_cnt_next = emit_block ? '0 : block_inc;

        push_en = s1_valid_reg ? {emit_block, emit_long, emit_short} : '0;
        push_data[0] = {LEVEL_SHORT, short_min_next, short_max_next, short_sum_next,
                        CNT_W'(short_inc), !emit_long && !emit_block};
        push_data[1] = {LEVEL_LONG, long_min_next, long_max_next, long_sum_next,
                        CNT_W'(long_inc), !emit_block};
        push_data[2] = {LEVEL_BLOCK, block_min_next, block_max_next, block_sum_next,
                        CNT_W'(block_inc), 1'b1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_cnt_reg <= '0;
            long_cnt_reg  <= '0;
            block_cnt_reg <= '0;
        end else if (s1_valid_reg) begin
            short_cnt_reg <= short_cnt_next;
            long_cnt_reg  <= long_cnt_next;
            block_cnt_reg <= block_cnt_next;
        end
        if (s1_valid_reg) begin
            short_min_reg <= short_min_next;
            short_max_reg <= short_max_next;
            short_sum_reg <= short_sum_next;
            long_min_reg  <= long_min_next;
            long_max_reg  <= long_max_next;
            long_sum_reg  <= long_sum_next;
            block_min_reg <= block_min_next;
            block_max_reg <= block_max_next;
            block_sum_reg <= block_sum_next;
        end
    end

    a_short_below_window: assert property (@(posedge aclk) disable iff (!aresetn)
        short_cnt_reg != SHORT_LAST)
        else $error("short window count reached the window length");

    a_end_emits_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && blk_end) |-> (push_en == {MAX_PUSH{1'b1}}))
        else $error("block end did not close every span");

endmodule

// ===== hw/rtl/amms_queue.sv =====
// Job queue between front and back end; takes up to three jobs a cycle in order.
// Uses amms_pkg for its depth and push width.
module amms_queue
    import amms_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [MAX_PUSH-1:0]              push_en,
    input  logic [MAX_PUSH-1:0][DATA_W-1:0]  push_data,
    output logic [QUEUE_CW-1:0]              used,
    output logic                             pop_valid,
    input  logic                             pop_ready,
    output logic [DATA_W-1:0]                pop_data
);

    logic [DATA_W-1:0]   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0] wr_reg, rd_reg;
    logic [QUEUE_CW-1:0] used_reg;
    logic [QUEUE_PW-1:0] pos [MAX_PUSH];
    logic [QUEUE_CW-1:0] npush;
    logic                pop;

    always_comb begin
        pos[0] = wr_reg;
        npush  = QUEUE_CW'(push_en[0]);
        for (int i = 1; i < MAX_PUSH; i++) begin
            pos[i] = pos[i-1] + QUEUE_PW'(push_en[i-1]);
            npush  = npush + QUEUE_CW'(push_en[i]);
        end
    end

    assign used      = used_reg;
    assign pop_valid = (used_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            used_reg <= '0;
        end else begin
            wr_reg   <= wr_reg + QUEUE_PW'(npush);
            rd_reg   <= rd_reg + QUEUE_PW'(pop);
            used_reg <= used_reg + npush - QUEUE_CW'(pop);
        end
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (push_en[i]) begin
                mem_reg[pos[i]] <= push_data[i];
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(used_reg) + int'(npush)) <= QUEUE_DEPTH)
        else $error("job queue overflow");

endmodule

// ===== hw/rtl/amms_back.sv =====
// Back end: divides each span's sum of squares by its count, takes the integer
// square root one bit a cycle and holds the result. Uses amms_pkg.
module amms_back
    import amms_pkg::*;
#(
    parameter int SHORT_WINDOW      = DEF_SHORT_WINDOW,
    parameter int LONG_WINDOW       = DEF_LONG_WINDOW,
    parameter int MAX_BLOCK_SAMPLES = DEF_MAX_BLOCK_SAMPLES,
    parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS,
    parameter int JOB_W = job_width(SAMPLE_BITS, SHORT_WINDOW, LONG_WINDOW,
                                    MAX_BLOCK_SAMPLES)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  logic [JOB_W-1:0]              pop_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_level,
    output logic signed [SAMPLE_BITS-1:0] m_min_value,
    output logic signed [SAMPLE_BITS-1:0] m_max_value,
    output logic [SAMPLE_BITS-1:0]        m_rms_value,
    output logic                          m_final_res
);

    localparam int SUM_W  = sum_width(SAMPLE_BITS, MAX_BLOCK_SAMPLES);
    localparam int CNT_W  = count_width(SHORT_WINDOW, LONG_WINDOW, MAX_BLOCK_SAMPLES);
    localparam int X_W    = 2 * SAMPLE_BITS;
    localparam int SR_W   = SAMPLE_BITS + 2;
    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]                    j_level;
    logic signed [SAMPLE_BITS-1:0] j_min, j_max;
    logic [SUM_W-1:0]              j_sum;
    logic [CNT_W-1:0]              j_cnt;
    logic                          j_final;

    logic [1:0]                    state_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [1:0]                    level_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg, max_reg;
    logic                          final_reg;
    logic [CNT_W-1:0]              cnt_reg, rem_reg, rem_next;
    logic [SUM_W-1:0]              quo_reg, quo_next;
    logic [CNT_W:0]                d_trial;
    logic                          d_ge;
    logic [X_W-1:0]                x_reg;
    logic [SAMPLE_BITS-1:0]        root_reg, root_next;
    logic [SR_W-1:0]               srem_reg, srem_next;
    logic [SR_W+1:0]               s_shift, s_trial;
    logic                          s_ge;
    logic                          out_load;

    logic                          m_valid_reg, m_final_reg;
    logic [1:0]                    m_level_reg;
    logic signed [SAMPLE_BITS-1:0] m_min_reg, m_max_reg;
    logic [SAMPLE_BITS-1:0]        m_rms_reg;

    assign {j_level, j_min, j_max, j_sum, j_cnt, j_final} = pop_data;
    assign pop_ready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    always_comb begin
        d_trial  = {rem_reg, quo_reg[SUM_W-1]};
        d_ge     = (d_trial >= {1'b0, cnt_reg});
        rem_next = d_ge ? CNT_W'(d_trial - {1'b0, cnt_reg}) : d_trial[CNT_W-1:0];
        quo_next = {quo_reg[SUM_W-2:0], d_ge};

        s_shift   = {srem_reg, x_reg[X_W-1 -: 2]};
        s_trial   = (SR_W + 2)'({root_reg, 2'b01});
        s_ge      = (s_shift >= s_trial);
        srem_next = s_ge ? SR_W'(s_shift - s_trial) : SR_W'(s_shift);
        root_next = {root_reg[SAMPLE_BITS-2:0], s_ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (step_reg == STEP_W'(1)) begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (step_reg == STEP_W'(1)) begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                level_reg <= j_level;
                min_reg   <= j_min;
                max_reg   <= j_max;
                final_reg <= j_final;
                cnt_reg   <= j_cnt;
                quo_reg   <= j_sum;
                rem_reg   <= '0;
                step_reg  <= STEP_W'(SUM_W);
            end
            ST_DIV: begin
                quo_reg  <= quo_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    x_reg    <= quo_next[X_W-1:0];
                    root_reg <= '0;
                    srem_reg <= '0;
                    step_reg <= STEP_W'(SAMPLE_BITS);
                end
            end
            ST_SQRT: begin
                x_reg    <= {x_reg[X_W-3:0], 2'b00};
                root_reg <= root_next;
                srem_reg <= srem_next;
                step_reg <= step_reg - STEP_W'(1);
            end
            ST_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_level_reg <= level_reg;
            m_min_reg   <= min_reg;
            m_max_reg   <= max_reg;
            m_rms_reg   <= root_reg;
            m_final_reg <= final_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_level     = m_level_reg;
    assign m_min_value = m_min_reg;
    assign m_max_value = m_max_reg;
    assign m_rms_value = m_rms_reg;
    assign m_final_res = m_final_reg;

    a_mean_fits_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && step_reg == STEP_W'(1)) |-> (quo_next[SUM_W-1:X_W] == '0))
        else $error("mean of squares wider than the root input");

endmodule

// ===== hw/rtl/audio_min_max_rms_summary.sv =====
// Top level of the audio min/max/rms summary block.
// Instantiates amms_front, amms_queue and amms_back; uses amms_pkg.
//
// Samples enter on the s_ channel (s_sample, s_block_end) with valid/ready and
// results leave on the m_ channel with valid/ready. Each accepted sample is
// squared in one register stage and then folded into the short window, long
// window and block accumulators. A span that closes puts a job in an
// eight-entry queue; a block end or the block length limit closes all three.
// The back end serves one job at a time: it takes the job while idle, divides
// the sum of squares by the sample count one quotient bit per cycle, takes the
// square root one root bit per cycle and then loads the output register.
// Samples are taken one per cycle while at most two jobs wait in the queue;
// with more waiting, s_ready falls until the back end catches up. A stalled
// receiver holds the output register and the back end, and the front keeps
// taking samples while at most two jobs wait. Reset clears the counts, the queue
// and the output valid; no storage needs a clearing pass.
module audio_min_max_rms_summary
    import amms_pkg::*;
#(
    parameter int SHORT_WINDOW      = DEF_SHORT_WINDOW,
    parameter int LONG_WINDOW       = DEF_LONG_WINDOW,
    parameter int MAX_BLOCK_SAMPLES = DEF_MAX_BLOCK_SAMPLES,
    parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_block_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_level,
    output logic signed [SAMPLE_BITS-1:0] m_min_value,
    output logic signed [SAMPLE_BITS-1:0] m_max_value,
    output logic [SAMPLE_BITS-1:0]        m_rms_value,
    output logic                          m_final_res
);

    localparam int JOB_W = job_width(SAMPLE_BITS, SHORT_WINDOW, LONG_WINDOW,
                                     MAX_BLOCK_SAMPLES);

    logic [QUEUE_CW-1:0]            q_used;
    logic [MAX_PUSH-1:0]            push_en;
    logic [MAX_PUSH-1:0][JOB_W-1:0] push_data;
    logic                           pop_valid, pop_ready;
    logic [JOB_W-1:0]               pop_data;

    amms_front #(
        .SHORT_WINDOW      (SHORT_WINDOW),
        .LONG_WINDOW       (LONG_WINDOW),
        .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
        .SAMPLE_BITS       (SAMPLE_BITS),
        .JOB_W             (JOB_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_block_end (s_block_end),
        .q_used      (q_used),
        .push_en     (push_en),
        .push_data   (push_data)
    );

    amms_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (push_en),
        .push_data (push_data),
        .used      (q_used),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    amms_back #(
        .SHORT_WINDOW      (SHORT_WINDOW),
        .LONG_WINDOW       (LONG_WINDOW),
        .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
        .SAMPLE_BITS       (SAMPLE_BITS),
        .JOB_W             (JOB_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_level     (m_level),
        .m_min_value (m_min_value),
        .m_max_value (m_max_value),
        .m_rms_value (m_rms_value),
        .m_final_res (m_final_res)
    );

endmodule
